// File: sv/dhcp_client_reply_parser_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef DHCP_CLIENT_REPLY_PARSER_UNIT_MACROS_SVH
`define DHCP_CLIENT_REPLY_PARSER_UNIT_MACROS_SVH

// plain property, sampled on the rising edge, off while reset is low
`define DCRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dcrp check failed");

// same-cycle implication
`define DCRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dcrp check failed");

// next-cycle implication
`define DCRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dcrp check failed");

`endif

// File: sv/dcrp_pkg.sv
// ----------------------------------------------------------------------------
// dcrp_pkg
// Types and constants of the DHCP client reply parser.
// ----------------------------------------------------------------------------
package dcrp_pkg;

  localparam int unsigned HEADER_BYTES = 240;
  localparam logic [31:0] XID_RESET    = 32'h1234_5678;

  localparam logic [7:0] OP_REPLY   = 8'd2;
  localparam logic [7:0] KIND_OFFER = 8'd2;
  localparam logic [7:0] KIND_ACK   = 8'd5;
  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_MASK   = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_TYPE   = 8'd53;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] OPT_END    = 8'd255;

  // result event codes
  localparam logic [1:0] EV_IGNORED  = 2'd0;
  localparam logic [1:0] EV_DISCOVER = 2'd1;
  localparam logic [1:0] EV_REQUEST  = 2'd2;
  localparam logic [1:0] EV_BOUND    = 2'd3;

  // client phase codes
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DISC     = 2'd1;
  localparam logic [1:0] PH_REQ      = 2'd2;
  localparam logic [1:0] PH_BOUND    = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       rx_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] offered_ip;
    logic [31:0] server_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] dns_server;
    logic [1:0]  client_status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_BYTE,
    CMD_LAST
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: sv/dcrp_front.sv
// ----------------------------------------------------------------------------
// dcrp_front
// Accepts input items and turns them into parser commands for the queue.
// ----------------------------------------------------------------------------
module dcrp_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dcrp_pkg::in_item_t  in_item_i,
  input  dcrp_pkg::q_status_t q_status_i,
  output logic                push_o,
  output dcrp_pkg::cmd_t      cmd_o
);

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    cmd_o.data = in_item_i.rx_byte;
    priority if (!in_item_i.action) begin
      cmd_o.kind = dcrp_pkg::CMD_START;
    end else if (in_item_i.rx_last) begin
      cmd_o.kind = dcrp_pkg::CMD_LAST;
    end else begin
      cmd_o.kind = dcrp_pkg::CMD_BYTE;
    end
  end

endmodule

// File: sv/dcrp_queue.sv
// ----------------------------------------------------------------------------
// dcrp_queue
// Small command FIFO between the front and the back of the parser.
// ----------------------------------------------------------------------------
module dcrp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dcrp_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output dcrp_pkg::cmd_t      cmd_o,
  output dcrp_pkg::q_status_t status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  dcrp_pkg::cmd_t mem_q [DEPTH];
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + AW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: sv/dcrp_back.sv
// ----------------------------------------------------------------------------
// dcrp_back
// Reply parser and client phase machine, with the registered result slot.
// ----------------------------------------------------------------------------
module dcrp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                cmd_valid_i,
  input  dcrp_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcrp_pkg::out_item_t out_item_o
);

  // option walker phases
  localparam logic [1:0] OPH_CODE = 2'd0;
  localparam logic [1:0] OPH_LEN  = 2'd1;
  localparam logic [1:0] OPH_VAL  = 2'd2;
  localparam logic [1:0] OPH_END  = 2'd3;

  logic [31:0] tid_q;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] xid_q, xid_d;
  logic [31:0] yip_q, yip_d;
  logic [1:0]  oph_q, oph_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  left_q, left_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] srv_q, srv_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] rtr_q, rtr_d;
  logic [31:0] dns_q, dns_d;

  logic                out_valid_q, out_valid_d;
  dcrp_pkg::out_item_t out_q, out_d;
  logic                has_result, slot_free, load_out;
  logic [7:0]          b;
  logic [1:0]          ev;

  assign b          = cmd_i.data;
  assign has_result = (cmd_i.kind != dcrp_pkg::CMD_BYTE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign pop_o      = cmd_valid_i && (!has_result || slot_free);
  assign load_out   = pop_o && has_result;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; op_d = op_q; xid_d = xid_q; yip_d = yip_q;
    oph_d = oph_q; code_d = code_q; left_d = left_q; idx_d = idx_q;
    kind_d = kind_q; srv_d = srv_q; mask_d = mask_q; rtr_d = rtr_q; dns_d = dns_q;
    out_d = out_q;
    ev    = dcrp_pkg::EV_IGNORED;

    if (pop_o) begin
      if (cmd_i.kind == dcrp_pkg::CMD_START) begin
        phase_d = dcrp_pkg::PH_DISC;
        out_d   = '0;
        out_d.event_res     = dcrp_pkg::EV_DISCOVER;
        out_d.client_status = dcrp_pkg::PH_DISC;
      end else begin
        if (32'(pos_q) < dcrp_pkg::HEADER_BYTES) begin
          if (pos_q == 8'd0) begin
            op_d = b;
          end else if (pos_q >= 8'd4 && pos_q <= 8'd7) begin
            xid_d = {xid_q[23:0], b};
          end else if (pos_q >= 8'd16 && pos_q <= 8'd19) begin
            yip_d[{pos_q[1:0], 3'b000} +: 8] = b;
          end
          pos_d = pos_q + 8'd1;
        end else begin
          unique case (oph_q)
            OPH_CODE: begin
              if (b == dcrp_pkg::OPT_END) begin
                oph_d = OPH_END;
              end else if (b != dcrp_pkg::OPT_PAD) begin
                code_d = b;
                oph_d  = OPH_LEN;
              end
            end
            OPH_LEN: begin
              left_d = b;
              idx_d  = 3'd0;
              unique case (code_q)
                dcrp_pkg::OPT_TYPE:   kind_d = '0;
                dcrp_pkg::OPT_MASK:   mask_d = '0;
                dcrp_pkg::OPT_ROUTER: rtr_d  = '0;
                dcrp_pkg::OPT_DNS:    dns_d  = '0;
                dcrp_pkg::OPT_SERVER: srv_d  = '0;
                default: ;
              endcase
              oph_d = (b == 8'd0) ? OPH_CODE : OPH_VAL;
            end
            OPH_VAL: begin
              // only the first four value bytes land; later ones are skipped
              if (!idx_q[2]) begin
                unique case (code_q)
                  dcrp_pkg::OPT_TYPE: begin
                    if (idx_q == 3'd0) kind_d = b;
                  end
                  dcrp_pkg::OPT_MASK:   mask_d[{idx_q[1:0], 3'b000} +: 8] = b;
                  dcrp_pkg::OPT_ROUTER: rtr_d[{idx_q[1:0], 3'b000} +: 8]  = b;
                  dcrp_pkg::OPT_DNS:    dns_d[{idx_q[1:0], 3'b000} +: 8]  = b;
                  dcrp_pkg::OPT_SERVER: srv_d[{idx_q[1:0], 3'b000} +: 8]  = b;
                  default: ;
                endcase
                idx_d = idx_q + 3'd1;
              end
              left_d = left_q - 8'd1;
              if (left_d == 8'd0) oph_d = OPH_CODE;
            end
            default: ;
          endcase
        end

        if (cmd_i.kind == dcrp_pkg::CMD_LAST) begin
          if (32'(pos_d) >= dcrp_pkg::HEADER_BYTES && op_d == dcrp_pkg::OP_REPLY &&
              xid_d == tid_q) begin
            if (phase_q == dcrp_pkg::PH_DISC && kind_d == dcrp_pkg::KIND_OFFER) begin
              phase_d = dcrp_pkg::PH_REQ;
              ev      = dcrp_pkg::EV_REQUEST;
            end else if (phase_q == dcrp_pkg::PH_REQ && kind_d == dcrp_pkg::KIND_ACK) begin
              phase_d = dcrp_pkg::PH_BOUND;
              ev      = dcrp_pkg::EV_BOUND;
            end
          end
          out_d = '0;
          out_d.event_res     = ev;
          out_d.client_status = phase_d;
          if (ev != dcrp_pkg::EV_IGNORED) begin
            out_d.offered_ip  = yip_d;
            out_d.server_ip   = srv_d;
            out_d.subnet_mask = mask_d;
            out_d.gateway_ip  = rtr_d;
            out_d.dns_server  = dns_d;
          end
        end
      end

      // start and last byte both leave a clean parser for the next reply
      if (has_result) begin
        pos_d = '0; op_d = '0; xid_d = '0; yip_d = '0; oph_d = OPH_CODE;
        code_d = '0; left_d = '0; idx_d = '0; kind_d = '0;
        srv_d = '0; mask_d = '0; rtr_d = '0; dns_d = '0;
      end
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_q <= dcrp_pkg::XID_RESET;
      phase_q <= dcrp_pkg::PH_IDLE;
      pos_q <= '0; op_q <= '0; xid_q <= '0; yip_q <= '0; oph_q <= OPH_CODE;
      code_q <= '0; left_q <= '0; idx_q <= '0; kind_q <= '0;
      srv_q <= '0; mask_q <= '0; rtr_q <= '0; dns_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) tid_q <= cfg_data_i;
      phase_q <= phase_d;
      pos_q <= pos_d; op_q <= op_d; xid_q <= xid_d; yip_q <= yip_d; oph_q <= oph_d;
      code_q <= code_d; left_q <= left_d; idx_q <= idx_d; kind_q <= kind_d;
      srv_q <= srv_d; mask_q <= mask_d; rtr_q <= rtr_d; dns_q <= dns_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= out_d;
  end

endmodule

// File: sv/dhcp_client_reply_parser_unit.sv
// ----------------------------------------------------------------------------
// dhcp_client_reply_parser_unit
// DHCP client: discovery start and byte-wise reply parsing.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_item_i): action 0 starts discovery,
// action 1 carries one reply payload byte, rx_last marking the final byte.
// Output channel (out_valid_o/out_ready_i, out_item_o): one result item per
// start and per last byte; other bytes give none.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): transaction id, always
// ready. The user must write it only while the block is idle; not enforced.
// Throughput: one item per cycle while the queue is not full. Items go through
// a QUEUE_DEPTH-entry command queue into the parser, which updates its state
// for each byte it pops. An accepted item is written into the queue; the parser
// pops it after any items ahead of it and loads its result into the register.
// Receiver stall: the result register holds, bytes without a result keep
// draining, and in_ready_o drops once the queue fills.
// Reset: client idle, parser cleared, transaction id 0x12345678, queue empty.
// ----------------------------------------------------------------------------
module dhcp_client_reply_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dcrp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dcrp_pkg::out_item_t out_item_o
);

  dcrp_pkg::q_status_t q_status;
  dcrp_pkg::cmd_t      push_cmd, head_cmd;
  logic                push, pop;

  assign cfg_ready_o = 1'b1;

  dcrp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  dcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  dcrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (!q_status.empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: sv/dcrp_checker.sv
// ----------------------------------------------------------------------------
// dcrp_checker
// Port-level checks of the DHCP client reply parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "dhcp_client_reply_parser_unit_macros.svh"

module dcrp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dcrp_pkg::out_item_t out_item_o
);

  logic no_values;
  logic stalled, no_report, disc_res, req_res, disc_ok, req_ok;

  assign no_values = (out_item_o.offered_ip == '0) && (out_item_o.server_ip == '0) &&
                     (out_item_o.subnet_mask == '0) && (out_item_o.gateway_ip == '0) &&
                     (out_item_o.dns_server == '0);

  assign stalled   = out_valid_o && !out_ready_i;
  assign no_report = out_valid_o && (out_item_o.event_res == dcrp_pkg::EV_IGNORED ||
                                     out_item_o.event_res == dcrp_pkg::EV_DISCOVER);
  assign disc_res  = out_valid_o && (out_item_o.event_res == dcrp_pkg::EV_DISCOVER);
  assign req_res   = out_valid_o && (out_item_o.event_res == dcrp_pkg::EV_REQUEST);
  assign disc_ok   = (out_item_o.client_status == dcrp_pkg::PH_DISC);
  assign req_ok    = (out_item_o.client_status == dcrp_pkg::PH_REQ);

  `DCRP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(out_item_o))

  // ignored and discover results carry no addresses
  `DCRP_ASSERT_IMP(a_zero_vals, clk_i, rst_ni, no_report, no_values)

  `DCRP_ASSERT_IMP(a_disc_status, clk_i, rst_ni, disc_res, disc_ok)

  `DCRP_ASSERT(a_req_status, clk_i, rst_ni, !req_res || req_ok)

endmodule

bind dhcp_client_reply_parser_unit dcrp_checker u_dcrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the DHCP client reply parser unit.
// Reply payloads are built byte by byte and sent as items together with
// discovery starts. A model of the client in this file predicts each result
// item, and the results are compared field by field in arrival order. Both
// sides pause at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import dcrp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEM_BUDGET  = 1450;
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  // captured option values
  localparam int SLOT_NONE   = -1;
  localparam int SLOT_SERVER = 0;
  localparam int SLOT_MASK   = 1;
  localparam int SLOT_ROUTER = 2;
  localparam int SLOT_DNS    = 3;

  typedef enum logic [1:0] {
    OPT_ST_CODE,
    OPT_ST_LEN,
    OPT_ST_VALUE,
    OPT_ST_END
  } opt_state_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;

  dhcp_client_reply_parser_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  always #4 clk_i = ~clk_i;

  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Client model
  // --------------------------------------------------------------------------
  logic [31:0] lease_xid   = XID_RESET;
  logic [1:0]  lease_phase = PH_IDLE;
  int unsigned hdr_pos     = 0;
  logic [7:0]  hdr_op      = '0;
  logic [31:0] hdr_xid     = '0;
  logic [31:0] hdr_yiaddr  = '0;
  opt_state_e  opt_state   = OPT_ST_CODE;
  logic [7:0]  opt_code    = '0;
  logic [7:0]  opt_left    = '0;
  logic [2:0]  opt_idx     = '0;
  logic [7:0]  msg_type    = '0;
  logic [31:0] opt_val [4] = '{default: '0};
  out_item_t   lease_q [$];

  int unsigned n_items      = 0;
  int unsigned mismatch_cnt = 0;

  function automatic void clear_reply_state();
    hdr_pos    = 0;
    hdr_op     = '0;
    hdr_xid    = '0;
    hdr_yiaddr = '0;
    opt_state  = OPT_ST_CODE;
    opt_code   = '0;
    opt_left   = '0;
    opt_idx    = '0;
    msg_type   = '0;
    for (int i = 0; i < 4; i++) opt_val[i] = '0;
  endfunction

  function automatic int slot_of(logic [7:0] code);
    case (code)
      OPT_MASK:   return SLOT_MASK;
      OPT_ROUTER: return SLOT_ROUTER;
      OPT_DNS:    return SLOT_DNS;
      OPT_SERVER: return SLOT_SERVER;
      default:    return SLOT_NONE;
    endcase
  endfunction

  function automatic void predict_item(in_item_t it);
    out_item_t  res;
    logic [7:0] b;
    int         s;
    res = '0;
    b   = it.rx_byte;
    if (it.action == ACT_START) begin
      clear_reply_state();
      lease_phase       = PH_DISC;
      res.event_res     = EV_DISCOVER;
      res.client_status = PH_DISC;
      lease_q.push_back(res);
    end else begin
      if (hdr_pos < HEADER_BYTES) begin
        if (hdr_pos == 0) hdr_op = b;
        else if (hdr_pos >= 4 && hdr_pos <= 7) hdr_xid = {hdr_xid[23:0], b};
        else if (hdr_pos >= 16 && hdr_pos <= 19) hdr_yiaddr[8*(hdr_pos-16) +: 8] = b;
        hdr_pos++;
      end else begin
        s = slot_of(opt_code);
        case (opt_state)
          OPT_ST_CODE: begin
            if (b == OPT_END) opt_state = OPT_ST_END;
            else if (b != OPT_PAD) begin
              opt_code  = b;
              opt_state = OPT_ST_LEN;
            end
          end
          OPT_ST_LEN: begin
            opt_left = b;
            opt_idx  = '0;
            if (opt_code == OPT_TYPE) msg_type = '0;
            if (s != SLOT_NONE) opt_val[s] = '0;
            opt_state = (b == 8'd0) ? OPT_ST_CODE : OPT_ST_VALUE;
          end
          OPT_ST_VALUE: begin
            // only the first four value bytes count
            if (opt_idx < 4) begin
              if (opt_code == OPT_TYPE && opt_idx == 0) msg_type = b;
              if (s != SLOT_NONE) opt_val[s][8*opt_idx +: 8] = b;
              opt_idx++;
            end
            opt_left--;
            if (opt_left == 8'd0) opt_state = OPT_ST_CODE;
          end
          default: ;
        endcase
      end
      if (it.rx_last) begin
        res.event_res = EV_IGNORED;
        if (hdr_pos >= HEADER_BYTES && hdr_op == OP_REPLY && hdr_xid == lease_xid) begin
          if (lease_phase == PH_DISC && msg_type == KIND_OFFER) begin
            lease_phase   = PH_REQ;
            res.event_res = EV_REQUEST;
          end else if (lease_phase == PH_REQ && msg_type == KIND_ACK) begin
            lease_phase   = PH_BOUND;
            res.event_res = EV_BOUND;
          end
        end
        if (res.event_res != EV_IGNORED) begin
          res.offered_ip  = hdr_yiaddr;
          res.server_ip   = opt_val[SLOT_SERVER];
          res.subnet_mask = opt_val[SLOT_MASK];
          res.gateway_ip  = opt_val[SLOT_ROUTER];
          res.dns_server  = opt_val[SLOT_DNS];
        end
        res.client_status = lease_phase;
        clear_reply_state();
        lease_q.push_back(res);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t ns: %s expected %08h, got %08h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lease_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t ns: result item with nothing pending, event %0d", $time,
                   out_item_o.event_res);
      end else begin
        want = lease_q.pop_front();
        check_field("event_res", want.event_res, out_item_o.event_res);
        check_field("offered_ip", want.offered_ip, out_item_o.offered_ip);
        check_field("server_ip", want.server_ip, out_item_o.server_ip);
        check_field("subnet_mask", want.subnet_mask, out_item_o.subnet_mask);
        check_field("gateway_ip", want.gateway_ip, out_item_o.gateway_ip);
        check_field("dns_server", want.dns_server, out_item_o.dns_server);
        check_field("client_status", want.client_status, out_item_o.client_status);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pacing of both sides
  // --------------------------------------------------------------------------
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_hold   = 0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned tx_gap();
    if (tx_steady || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  initial begin : rx_pacing
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        n       = rx_hold;
        rx_hold = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else if (rx_steady || $urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (idle_len() - 1) @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item and packet senders
  // --------------------------------------------------------------------------
  logic [7:0] pkt [$];

  task automatic send_item(in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
    n_items++;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_start();
    in_item_t it;
    it.action  = ACT_START;
    it.rx_byte = 8'($urandom);
    it.rx_last = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_pkt(bit mark_last);
    in_item_t it;
    for (int i = 0; i < pkt.size(); i++) begin
      it.action  = ACT_BYTE;
      it.rx_byte = pkt[i];
      it.rx_last = mark_last && (i == pkt.size() - 1);
      send_item(it);
    end
    pkt.delete();
  endtask

  function automatic void put_header(logic [7:0] op, logic [31:0] xid, logic [31:0] yiaddr);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (i == 0) pkt.push_back(op);
      else if (i >= 4 && i <= 7) pkt.push_back(xid[8*(7-i) +: 8]);
      else if (i >= 16 && i <= 19) pkt.push_back(yiaddr[8*(i-16) +: 8]);
      else pkt.push_back(8'($urandom));
    end
  endfunction

  function automatic void put_opt(logic [7:0] code, logic [7:0] len, logic [31:0] val);
    pkt.push_back(code);
    pkt.push_back(len);
    for (int i = 0; i < len; i++) begin
      if (i < 4) pkt.push_back(val[8*i +: 8]);
      else pkt.push_back(8'($urandom));
    end
  endfunction

  function automatic logic [7:0] opt_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return 8'd4;
    if (r < 19) return 8'($urandom_range(0, 8));
    return 8'($urandom_range(9, 255));
  endfunction

  function automatic void put_random_opts(logic [7:0] kind);
    int unsigned n, type_at;
    n       = $urandom_range(0, 6);
    type_at = $urandom_range(0, n);
    for (int i = 0; i <= n; i++) begin
      if (i == type_at) begin
        put_opt(OPT_TYPE, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 4)) : 8'd1,
                {24'($urandom), kind});
      end else begin
        case ($urandom_range(0, 5))
          0:       repeat ($urandom_range(1, 3)) pkt.push_back(OPT_PAD);
          1:       put_opt(OPT_MASK, opt_len(), $urandom);
          2:       put_opt(OPT_ROUTER, opt_len(), $urandom);
          3:       put_opt(OPT_DNS, opt_len(), $urandom);
          4:       put_opt(OPT_SERVER, opt_len(), $urandom);
          default: put_opt(8'($urandom_range(2, 254)), opt_len(), $urandom);
        endcase
      end
    end
    if ($urandom_range(0, 6) != 0) begin
      pkt.push_back(OPT_END);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
    end
  endfunction

  // complete reply with all four address options
  task automatic send_lease(logic [7:0] op, logic [31:0] xid, logic [7:0] kind);
    put_header(op, xid, $urandom);
    put_opt(OPT_TYPE, 8'd1, {24'd0, kind});
    put_opt(OPT_MASK, 8'd4, $urandom);
    put_opt(OPT_ROUTER, 8'd4, $urandom);
    put_opt(OPT_DNS, 8'd4, $urandom);
    put_opt(OPT_SERVER, 8'd4, $urandom);
    pkt.push_back(OPT_END);
    send_pkt(1'b1);
  endtask

  // wait until every result is out and the command queue has emptied
  task automatic drain();
    in_valid_i <= 1'b0;
    while (lease_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_xid(logic [31:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lease_xid = v;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_default_id_session();
    send_start();
    put_header(OP_REPLY, XID_RESET, 32'hFFFF_FFFF);
    put_opt(OPT_TYPE, 8'd1, {24'd0, KIND_OFFER});
    put_opt(OPT_MASK, 8'd4, 32'hFFFF_FF00);
    put_opt(OPT_ROUTER, 8'd4, 32'h0000_0000);
    put_opt(OPT_DNS, 8'd4, 32'hFFFF_FFFF);
    put_opt(OPT_SERVER, 8'd4, 32'h0100_00FF);
    pkt.push_back(OPT_END);
    send_pkt(1'b1);
    send_lease(OP_REPLY, XID_RESET, KIND_ACK);
  endtask

  task automatic test_reply_rejects();
    pkt.push_back(OP_REPLY);
    send_pkt(1'b1);                               // one-byte reply
    send_start();
    send_lease(OP_REPLY, lease_xid ^ 32'd1, KIND_OFFER);
  endtask

  task automatic test_option_forms();
    send_start();
    put_header(OP_REPLY, lease_xid, $urandom);
    pkt.push_back(OPT_PAD);
    pkt.push_back(OPT_PAD);
    put_opt(OPT_MASK, 8'd2, $urandom);
    put_opt(OPT_ROUTER, 8'd0, $urandom);
    put_opt(OPT_DNS, 8'd7, $urandom);
    put_opt(OPT_SERVER, 8'd4, $urandom);
    put_opt(8'd200, 8'd5, $urandom);
    put_opt(OPT_SERVER, 8'd3, $urandom);          // replaces the first one
    put_opt(OPT_TYPE, 8'd3, {24'($urandom), KIND_OFFER});
    pkt.push_back(OPT_END);
    put_opt(OPT_TYPE, 8'd1, {24'd0, KIND_ACK});   // after end: no effect
    send_pkt(1'b1);
  endtask

  task automatic test_restart_midway();
    send_start();
    repeat (10) pkt.push_back(8'($urandom));
    send_pkt(1'b0);
    send_start();
  endtask

  task automatic test_id_register();
    write_xid(32'h0000_0000);
    send_start();
    send_lease(OP_REPLY, 32'h0000_0000, KIND_OFFER);
  endtask

  // receiver holds off while short replies keep coming
  task automatic test_output_stall();
    drain();
    rx_hold   = 300;
    tx_steady = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_start();
      else begin
        pkt.push_back(8'($urandom));
        send_pkt(1'b1);
      end
    end
    tx_steady = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned r, trans, keep;
    logic [7:0]  kind, op;
    logic [31:0] xid;
    trans = 0;
    while (n_items < ITEM_BUDGET) begin
      trans++;
      if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
      if (trans % 16 == 0 && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 4))
          0:       write_xid(32'h0000_0000);
          1:       write_xid(32'hFFFF_FFFF);
          2:       write_xid(XID_RESET);
          default: write_xid($urandom);
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 10 || ((lease_phase == PH_IDLE || lease_phase == PH_BOUND) && r < 50)) begin
        send_start();
      end else if (r < 85) begin
        op   = OP_REPLY;
        xid  = lease_xid;
        kind = (lease_phase == PH_REQ) ? KIND_ACK : KIND_OFFER;
        // a share of replies with one thing wrong
        if (r >= 75) begin
          case ($urandom_range(0, 2))
            0:       op = 8'($urandom_range(0, 3));
            1:       xid = $urandom;
            default: kind = 8'($urandom_range(0, 8));
          endcase
        end
        put_header(op, xid, $urandom);
        put_random_opts(kind);
        if ($urandom_range(0, 9) == 0) begin
          keep = $urandom_range(HEADER_BYTES + 1, pkt.size());
          while (pkt.size() > keep) void'(pkt.pop_back());
        end
        send_pkt(1'b1);
      end else if (r < 93) begin
        keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, HEADER_BYTES - 1)
                                           : $urandom_range(1, 24);
        repeat (keep) pkt.push_back(8'($urandom));
        send_pkt(1'b1);
      end else begin
        put_header($urandom_range(0, 1) ? OP_REPLY : 8'($urandom), lease_xid, $urandom);
        repeat ($urandom_range(0, 60)) pkt.push_back(8'($urandom));
        send_pkt(1'b1);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : run
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_id_session();
    test_reply_rejects();
    test_option_forms();
    test_restart_midway();
    test_id_register();
    test_output_stall();
    test_random_traffic();
    drain();
    if (mismatch_cnt == 0 && lease_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/dcrp_pkg.sv
sv/dcrp_front.sv
sv/dcrp_queue.sv
sv/dcrp_back.sv
sv/dhcp_client_reply_parser_unit.sv
sv/dcrp_checker.sv
test/tb.sv
